// File: hdl/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescape unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Most results a single input byte can cause: three bytes for a held high
  // surrogate, three for the following escape, and one end-of-text error.
  localparam int unsigned MAX_RESULTS = 7;
  localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // All results caused by one input byte, in order.
  typedef struct packed {
    logic [CNT_W-1:0]                  count;
    logic [MAX_RESULTS-1:0][7:0]       data;
    logic [MAX_RESULTS-1:0][1:0]       kinds;
  } job_t;

endpackage

// File: hdl/jsu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front
// Decoder front end: runs the escape state machine for each accepted byte and
// builds the list of results that byte causes.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  logic             in_first_byte,
  input  logic             in_end_of_text,
  output jsu_pkg::job_t    job,
  output logic             job_push
);

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_STR     = 3'd1,
    M_ESC     = 3'd2,
    M_HEX     = 3'd3,
    M_HIGH    = 3'd4,
    M_HIGH_BS = 3'd5,
    M_LOW_HEX = 3'd6
  } mode_t;

  typedef struct packed {
    mode_t          mode;
    logic [15:0]    acc;
    logic [1:0]     cnt;
    logic [15:0]    held;
    jsu_pkg::job_t  job;
  } dec_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  localparam logic [15:0] HIGH_LO = 16'hD800;
  localparam logic [15:0] HIGH_HI = 16'hDBFF;
  localparam logic [15:0] LOW_LO  = 16'hDC00;
  localparam logic [15:0] LOW_HI  = 16'hDFFF;

  mode_t       mode_r;
  logic [15:0] acc_r;
  logic [1:0]  cnt_r;
  logic [15:0] held_r;
  dec_t        dec_nxt;

  // {valid, value} of an ASCII hex digit, either case
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    case (b) inside
      [8'h30:8'h39]: r = {1'b1, b[3:0]};
      [8'h61:8'h66],
      [8'h41:8'h46]: r = {1'b1, b[3:0] + 4'd9};
      default:       r = '0;
    endcase
    return r;
  endfunction

  function automatic jsu_pkg::job_t put(input jsu_pkg::job_t j, input logic [7:0] b,
                                        input logic [1:0] k);
    jsu_pkg::job_t r;
    r = j;
    if (j.count < jsu_pkg::CNT_W'(jsu_pkg::MAX_RESULTS)) begin
      r.data[j.count[jsu_pkg::IDX_W-1:0]]  = b;
      r.kinds[j.count[jsu_pkg::IDX_W-1:0]] = k;
      r.count = j.count + 1'b1;
    end
    return r;
  endfunction

  function automatic jsu_pkg::job_t put_utf8(input jsu_pkg::job_t j, input logic [20:0] cp);
    jsu_pkg::job_t r;
    r = j;
    if (cp <= 21'h7F) begin
      r = put(r, cp[7:0], jsu_pkg::KIND_DATA);
    end else if (cp <= 21'h7FF) begin
      r = put(r, {3'b110, cp[10:6]}, jsu_pkg::KIND_DATA);
      r = put(r, {2'b10, cp[5:0]}, jsu_pkg::KIND_DATA);
    end else if (cp <= 21'hFFFF) begin
      r = put(r, {4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA);
      r = put(r, {2'b10, cp[11:6]}, jsu_pkg::KIND_DATA);
      r = put(r, {2'b10, cp[5:0]}, jsu_pkg::KIND_DATA);
    end else begin
      r = put(r, {5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA);
      r = put(r, {2'b10, cp[17:12]}, jsu_pkg::KIND_DATA);
      r = put(r, {2'b10, cp[11:6]}, jsu_pkg::KIND_DATA);
      r = put(r, {2'b10, cp[5:0]}, jsu_pkg::KIND_DATA);
    end
    return r;
  endfunction

  function automatic dec_t go_idle(input dec_t d);
    dec_t r;
    r = d;
    r.mode = M_IDLE;
    r.acc  = '0;
    r.cnt  = '0;
    r.held = '0;
    return r;
  endfunction

  function automatic dec_t fail(input dec_t d);
    dec_t r;
    r = d;
    r.job = put(r.job, 8'h00, jsu_pkg::KIND_ERROR);
    return go_idle(r);
  endfunction

  function automatic dec_t text_byte(input dec_t d, input logic [7:0] b);
    dec_t r;
    r = d;
    if (b == CH_QUOTE) begin
      r.job = put(r.job, 8'h00, jsu_pkg::KIND_DONE);
      r = go_idle(r);
    end else if (b == CH_BSLASH) begin
      r.mode = M_ESC;
    end else begin
      r.job  = put(r.job, b, jsu_pkg::KIND_DATA);
      r.mode = M_STR;
    end
    return r;
  endfunction

  function automatic dec_t escape_byte(input dec_t d, input logic [7:0] b);
    dec_t       r;
    logic [7:0] c;
    logic       ok;
    r  = d;
    c  = b;
    ok = 1'b1;
    case (b)
      CH_QUOTE, CH_BSLASH, CH_SLASH: c = b;
      CH_B:    c = 8'h08;
      CH_F:    c = 8'h0C;
      CH_N:    c = 8'h0A;
      CH_R:    c = 8'h0D;
      CH_T:    c = 8'h09;
      default: ok = 1'b0;
    endcase
    if (b == CH_U) begin
      r.mode = M_HEX;
      r.acc  = '0;
      r.cnt  = '0;
    end else if (ok) begin
      r.job  = put(r.job, c, jsu_pkg::KIND_DATA);
      r.mode = M_STR;
    end else begin
      r = fail(r);
    end
    return r;
  endfunction

  function automatic dec_t first_escape_done(input dec_t d, input logic [15:0] cp);
    dec_t r;
    r = d;
    if (cp >= HIGH_LO && cp <= HIGH_HI) begin
      r.held = cp;
      r.mode = M_HIGH;
    end else begin
      r.job  = put_utf8(r.job, {5'd0, cp});
      r.mode = M_STR;
    end
    return r;
  endfunction

  always_comb begin
    dec_t        d;
    logic [4:0]  hx;
    logic [15:0] acc_g;
    logic        hex_full;
    d.mode = mode_r;
    d.acc  = acc_r;
    d.cnt  = cnt_r;
    d.held = held_r;
    d.job  = '0;
    hx       = hex_val(in_byte);
    acc_g    = {acc_r[11:0], hx[3:0]};
    hex_full = (cnt_r == 2'd3);

    if (in_first_byte) begin
      d = go_idle(d);
      if (in_byte == CH_QUOTE) begin
        d.mode = M_STR;
      end else begin
        d = fail(d);
      end
    end else begin
      case (mode_r)
        M_STR: begin
          d = text_byte(d, in_byte);
        end
        M_ESC: begin
          d = escape_byte(d, in_byte);
        end
        M_HEX, M_LOW_HEX: begin
          if (!hx[4]) begin
            d = fail(d);
          end else begin
            d.acc = acc_g;
            d.cnt = cnt_r + 2'd1;
            if (hex_full) begin
              if (mode_r == M_HEX) begin
                d = first_escape_done(d, acc_g);
              end else begin
                d.held = '0;
                if (acc_g >= LOW_LO && acc_g <= LOW_HI) begin
                  // surrogate pair: 0x10000 + hi[9:0]:lo[9:0]
                  d.job  = put_utf8(d.job, 21'h10000 + {1'b0, held_r[9:0], acc_g[9:0]});
                  d.mode = M_STR;
                end else begin
                  d.job = put_utf8(d.job, {5'd0, held_r});
                  d = first_escape_done(d, acc_g);
                end
              end
            end
          end
        end
        M_HIGH: begin
          if (in_byte == CH_BSLASH) begin
            d.mode = M_HIGH_BS;
          end else begin
            d.job  = put_utf8(d.job, {5'd0, held_r});
            d.held = '0;
            d = text_byte(d, in_byte);
          end
        end
        M_HIGH_BS: begin
          if (in_byte == CH_U) begin
            d.mode = M_LOW_HEX;
            d.acc  = '0;
            d.cnt  = '0;
          end else begin
            d.job  = put_utf8(d.job, {5'd0, held_r});
            d.held = '0;
            d = escape_byte(d, in_byte);
          end
        end
        default: begin
          d.mode = M_IDLE;
        end
      endcase
    end

    if (in_end_of_text && d.mode != M_IDLE) begin
      d = fail(d);
    end
    dec_nxt = d;
  end

  assign job      = dec_nxt.job;
  assign job_push = accept && (dec_nxt.job.count != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      acc_r  <= '0;
      cnt_r  <= '0;
      held_r <= '0;
    end else if (accept) begin
      mode_r <= dec_nxt.mode;
      acc_r  <= dec_nxt.acc;
      cnt_r  <= dec_nxt.cnt;
      held_r <= dec_nxt.held;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end_of_text |=> mode_r == M_IDLE)
    else $error("decoder not idle after end of text");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_IDLE |-> held_r == '0 && cnt_r == '0)
    else $error("idle decoder holds leftover state");
`endif

endmodule

// File: hdl/jsu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_queue
// Small FIFO of result lists between the decoder front end and the emitter.
// ----------------------------------------------------------------------------
module jsu_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jsu_pkg::job_t  push_data,
  output logic           full,
  input  logic           pop,
  output jsu_pkg::job_t  pop_data,
  output logic           empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  jsu_pkg::job_t     mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// File: hdl/jsu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back
// Emitter: walks each result list into the output register one entry per
// cycle while not stalled, and marks the last result of each input byte.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  jsu_pkg::job_t  job,
  output logic           job_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic [1:0]     out_kind,
  output logic           out_last_of_run
);

  jsu_pkg::job_t               cur_r;
  logic                        cur_valid_r;
  logic [jsu_pkg::IDX_W-1:0]   idx_r;
  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  logic [1:0]                  out_kind_r;
  logic                        out_last_r;

  logic out_load;
  logic advance;
  logic cur_last;
  logic cur_free;

  assign out_load = !out_valid_r || !out_stall;
  assign advance  = cur_valid_r && out_load;
  assign cur_last = (idx_r == cur_r.count - 1'b1);
  assign cur_free = !cur_valid_r || (advance && cur_last);
  assign job_pop  = cur_free && job_valid;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= cur_r.data[idx_r];
      out_kind_r <= cur_r.kinds[idx_r];
      out_last_r <= cur_last;
    end
    if (job_pop) begin
      cur_r <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (job_pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (advance) begin
        if (cur_last) begin
          cur_valid_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_kind        = out_kind_r;
  assign out_last_of_run = out_last_r;

`ifndef NO_ASSERTIONS
  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> cur_r.count != '0 && idx_r < cur_r.count)
    else $error("emitter index outside result list");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_kind_r != 2'd3)
    else $error("illegal result kind");
`endif

endmodule

// File: hdl/json_string_unescape_utf8_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// Streaming decoder of quoted JSON strings into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one text byte per item, with
//   in_first_byte on the opening quote and in_end_of_text on the last byte.
//   Result channel (out_valid / out_stall): one decoded byte, done mark or
//   error mark per item; out_last_of_run flags the last result of an input.
//   An input byte is decoded in the cycle it is accepted, and its result
//   list goes into a queue of QUEUE_DEPTH entries. The emitter drains one
//   result per cycle while the output is not stalled; each result passes
//   from the queue through the emitter's current list to the output register.
//   Throughput: one input byte per cycle while each byte yields at most one
//   result and the output is not stalled; a byte that yields more than one
//   result (up to 7, e.g. a lone surrogate followed by an escape) holds the
//   emitter until all are sent, and in_stall rises only once the queue is full.
//   Bytes that yield no result (opening quote, backslash, hex digits of an
//   unfinished escape, idle bytes) never reach the queue.
//   A stalled result holds in the output register; the queue absorbs the
//   input side meanwhile. Reset empties the queue and output and returns
//   the decoder to idle, waiting for a first byte.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_first_byte,
  input  logic        in_end_of_text,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic        out_last_of_run
);

  jsu_pkg::job_t front_job;
  jsu_pkg::job_t head_job;
  logic          front_push;
  logic          q_full;
  logic          q_empty;
  logic          back_pop;
  logic          accept;

  // Front end only waits on the queue; its state advances on every accepted
  // item regardless of what the result side is doing.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  jsu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_byte        (in_byte),
    .in_first_byte  (in_first_byte),
    .in_end_of_text (in_end_of_text),
    .job            (front_job),
    .job_push       (front_push)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_data (front_job),
    .full      (q_full),
    .pop       (back_pop),
    .pop_data  (head_job),
    .empty     (q_empty)
  );

  jsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (!q_empty),
    .job             (head_job),
    .job_pop         (back_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_kind        (out_kind),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// File: tb/json_string_unescape_utf8_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit_tb
// Self-checking bench for the JSON string unescape unit. It streams quoted
// strings byte by byte and keeps a cycle-free decoder model in step with
// every accepted byte. Each decoded UTF-8 byte, done mark and error mark the
// unit sends back is checked in order against that model.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  // Text bytes that the decoder treats specially
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef enum logic [3:0] {
    DM_IDLE, DM_TEXT, DM_ESC, DM_HEX, DM_HIGH, DM_HIGH_BS, DM_LOW_HEX
  } dec_mode_t;

  // Code point classes for generated \u escapes
  typedef enum int {CP_ONE, CP_TWO, CP_THREE, CP_HIGH, CP_LOW} cp_class_t;

  typedef struct {
    logic [7:0] b;
    bit         first;
    bit         eot;
  } text_item_t;

  typedef struct {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_first_byte = 1'b0;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last_of_run;

  // Decoder model state
  dec_mode_t   mode = DM_IDLE;
  logic [15:0] hex_acc = '0;
  logic [1:0]  hex_cnt = '0;
  logic [15:0] held_high = '0;

  decoded_t   byte_results[$];  // results of the byte being modeled
  decoded_t   decoded_q[$];     // results still owed by the unit
  text_item_t text_q[$];        // bytes waiting to be offered

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int n_items = 0;
  int n_fail = 0;
  int cycles = 0;

  json_string_unescape_utf8_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_first_byte  (in_first_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_last_of_run(out_last_of_run)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("json_string_unescape_utf8_unit verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------
  function void add_result(logic [7:0] d, logic [1:0] k);
    decoded_t r;
    r.data = d;
    r.kind = k;
    r.last = 1'b0;
    if (byte_results.size() < int'(jsu_pkg::MAX_RESULTS))
      byte_results.insert(byte_results.size(), r);
  endfunction

  function void add_utf8(int unsigned cp);
    if (cp <= 'h7F) begin
      add_result(cp[7:0], jsu_pkg::KIND_DATA);
    end else if (cp <= 'h7FF) begin
      add_result(8'hC0 | cp[10:6], jsu_pkg::KIND_DATA);
      add_result(8'h80 | cp[5:0], jsu_pkg::KIND_DATA);
    end else if (cp <= 'hFFFF) begin
      add_result(8'hE0 | cp[15:12], jsu_pkg::KIND_DATA);
      add_result(8'h80 | cp[11:6], jsu_pkg::KIND_DATA);
      add_result(8'h80 | cp[5:0], jsu_pkg::KIND_DATA);
    end else begin
      add_result(8'hF0 | cp[20:18], jsu_pkg::KIND_DATA);
      add_result(8'h80 | cp[17:12], jsu_pkg::KIND_DATA);
      add_result(8'h80 | cp[11:6], jsu_pkg::KIND_DATA);
      add_result(8'h80 | cp[5:0], jsu_pkg::KIND_DATA);
    end
  endfunction

  function void clear_decoder();
    mode = DM_IDLE;
    hex_acc = '0;
    hex_cnt = '0;
    held_high = '0;
  endfunction

  function void raise_error();
    add_result(8'h00, jsu_pkg::KIND_ERROR);
    clear_decoder();
  endfunction

  function int hex_value(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
    return -1;
  endfunction

  function void text_char(logic [7:0] b);
    if (b == CH_QUOTE) begin
      add_result(8'h00, jsu_pkg::KIND_DONE);
      clear_decoder();
    end else if (b == CH_BSLASH) begin
      mode = DM_ESC;
    end else begin
      add_result(b, jsu_pkg::KIND_DATA);
      mode = DM_TEXT;
    end
  endfunction

  function void escape_char(logic [7:0] b);
    logic [7:0] c;
    bit         emit;
    emit = 1'b1;
    c = b;
    case (b)
      CH_QUOTE, CH_BSLASH, CH_SLASH: c = b;
      CH_B: c = 8'h08;
      CH_F: c = 8'h0C;
      CH_N: c = 8'h0A;
      CH_R: c = 8'h0D;
      CH_T: c = 8'h09;
      CH_U: begin
        mode = DM_HEX;
        hex_acc = '0;
        hex_cnt = '0;
        emit = 1'b0;
      end
      default: begin
        raise_error();
        emit = 1'b0;
      end
    endcase
    if (emit) begin
      add_result(c, jsu_pkg::KIND_DATA);
      mode = DM_TEXT;
    end
  endfunction

  // A finished first escape: a high surrogate waits for its partner
  function void first_escape_value(logic [15:0] cp);
    if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
      held_high = cp;
      mode = DM_HIGH;
    end else begin
      add_utf8(32'(cp));
      mode = DM_TEXT;
    end
  endfunction

  // Returns 1 once the fourth digit is in
  function bit take_hex(logic [7:0] b);
    int d;
    d = hex_value(b);
    if (d < 0) begin
      raise_error();
      return 1'b0;
    end
    hex_acc = {hex_acc[11:0], d[3:0]};
    if (hex_cnt == 2'd3) begin
      hex_cnt = '0;
      return 1'b1;
    end
    hex_cnt = hex_cnt + 2'd1;
    return 1'b0;
  endfunction

  function void decode_item(text_item_t it);
    int unsigned lo;
    int unsigned hi;
    byte_results.delete();
    if (it.first) begin
      clear_decoder();
      if (it.b == CH_QUOTE) mode = DM_TEXT;
      else raise_error();
    end else begin
      case (mode)
        DM_TEXT: text_char(it.b);
        DM_ESC:  escape_char(it.b);
        DM_HEX:  if (take_hex(it.b)) first_escape_value(hex_acc);
        DM_HIGH: begin
          if (it.b == CH_BSLASH) begin
            mode = DM_HIGH_BS;
          end else begin
            add_utf8(32'(held_high));
            held_high = '0;
            text_char(it.b);
          end
        end
        DM_HIGH_BS: begin
          if (it.b == CH_U) begin
            mode = DM_LOW_HEX;
            hex_acc = '0;
            hex_cnt = '0;
          end else begin
            add_utf8(32'(held_high));
            held_high = '0;
            escape_char(it.b);
          end
        end
        DM_LOW_HEX: begin
          if (take_hex(it.b)) begin
            lo = 32'(hex_acc);
            hi = 32'(held_high);
            held_high = '0;
            if (lo >= 'hDC00 && lo <= 'hDFFF) begin
              add_utf8('h10000 + ((hi - 'hD800) << 10) + (lo - 'hDC00));
              mode = DM_TEXT;
            end else begin
              // not a low half: flush the high one, decode this one afresh
              add_utf8(hi);
              first_escape_value(lo[15:0]);
            end
          end
        end
        default: mode = DM_IDLE;
      endcase
    end
    if (it.eot && mode != DM_IDLE) raise_error();
    if (byte_results.size() > 0) byte_results[byte_results.size()-1].last = 1'b1;
    foreach (byte_results[i]) decoded_q.insert(decoded_q.size(), byte_results[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Text generation
  // --------------------------------------------------------------------------
  function void push_byte(logic [7:0] b, bit first = 1'b0, bit eot = 1'b0);
    text_item_t it;
    it.b = b;
    it.first = first;
    it.eot = eot;
    text_q.insert(text_q.size(), it);
    n_items++;
  endfunction

  // Stray bytes outside any string; not counted as items
  function void push_stray_bytes();
    text_item_t it;
    repeat ($urandom_range(3, 1)) begin
      it.b = 8'($urandom_range(255));
      it.first = 1'b0;
      it.eot = 1'($urandom_range(1));
      text_q.insert(text_q.size(), it);
    end
  endfunction

  function logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  function void push_uesc(logic [15:0] v);
    push_byte(CH_BSLASH);
    push_byte(CH_U);
    for (int i = 3; i >= 0; i--) push_byte(hex_char(v[i*4 +: 4]));
  endfunction

  // Random code point of a class, edges of the range picked often
  function logic [15:0] pick_code(cp_class_t c);
    int unsigned lo;
    int unsigned hi;
    case (c)
      CP_ONE: begin
        lo = 'h0;
        hi = 'h7F;
      end
      CP_TWO: begin
        lo = 'h80;
        hi = 'h7FF;
      end
      CP_THREE: begin
        if ($urandom_range(1)) begin
          lo = 'h800;
          hi = 'hD7FF;
        end else begin
          lo = 'hE000;
          hi = 'hFFFF;
        end
      end
      CP_HIGH: begin
        lo = 'hD800;
        hi = 'hDBFF;
      end
      default: begin
        lo = 'hDC00;
        hi = 'hDFFF;
      end
    endcase
    case ($urandom_range(3))
      0: return lo[15:0];
      1: return hi[15:0];
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  function logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function logic [7:0] simple_esc();
    case ($urandom_range(7))
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  function logic [7:0] bad_esc();
    logic [7:0] b;
    bit         bad;
    do begin
      b = 8'($urandom_range(255));
      case (b)
        CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: bad = 1'b0;
        default: bad = 1'b1;
      endcase
    end while (!bad);
    return b;
  endfunction

  function logic [7:0] bad_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (hex_value(b) >= 0);
    return b;
  endfunction

  function void push_token();
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7: push_byte(plain_char());
      8, 9: begin
        push_byte(CH_BSLASH);
        push_byte(simple_esc());
      end
      10, 11, 12: push_uesc(pick_code(cp_class_t'($urandom_range(2))));
      13, 14: begin
        push_uesc(pick_code(CP_HIGH));
        push_uesc(pick_code(CP_LOW));
      end
      15: begin
        // lone high, then plain text
        push_uesc(pick_code(CP_HIGH));
        push_byte(plain_char());
      end
      16: begin
        // lone high, then a simple escape
        push_uesc(pick_code(CP_HIGH));
        push_byte(CH_BSLASH);
        push_byte(simple_esc());
      end
      17: begin
        // high, then a \u that is not a low half (maybe another high)
        push_uesc(pick_code(CP_HIGH));
        push_uesc(pick_code(cp_class_t'($urandom_range(3))));
      end
      18: push_uesc(pick_code(CP_LOW));
      default: begin
        push_uesc(pick_code(CP_HIGH));
        push_uesc(pick_code(CP_HIGH));
        push_uesc(pick_code(CP_LOW));
      end
    endcase
  endfunction

  // One string: mostly well formed, with every way of ending badly mixed in
  function void push_string();
    if ($urandom_range(19) == 0) begin
      push_byte(plain_char(), 1'b1);
      if ($urandom_range(1)) push_stray_bytes();
      return;
    end
    push_byte(CH_QUOTE, 1'b1);
    repeat ($urandom_range(6)) push_token();
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
        if ($urandom_range(3) == 0) push_uesc(pick_code(CP_HIGH));
        push_byte(CH_QUOTE, 1'b0, $urandom_range(7) == 0);
      end
      13: text_q[text_q.size()-1].eot = 1'b1;
      14: begin
        if ($urandom_range(1)) push_uesc(pick_code(CP_HIGH));
        push_byte(CH_BSLASH);
        push_byte(bad_esc());
      end
      15: begin
        if ($urandom_range(1)) push_uesc(pick_code(CP_HIGH));
        push_byte(CH_BSLASH);
        push_byte(CH_U);
        repeat ($urandom_range(3)) push_byte(hex_char(4'($urandom_range(15))));
        push_byte(bad_hex());
      end
      16: begin
        // text runs out inside an escape
        push_byte(CH_BSLASH);
        push_byte(CH_U);
        repeat ($urandom_range(3)) push_byte(hex_char(4'($urandom_range(15))));
        text_q[text_q.size()-1].eot = 1'b1;
      end
      17: ;  // left open: the next opening quote drops it
      18: begin
        push_uesc(pick_code(CP_HIGH));
        text_q[text_q.size()-1].eot = 1'b1;
      end
      default: begin
        push_byte(CH_QUOTE);
        push_stray_bytes();
      end
    endcase
    if ($urandom_range(4) == 0) push_stray_bytes();
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers and result checker
  // --------------------------------------------------------------------------

  // Offers one item and returns at the edge where it is accepted, valid still
  // high. Handshakes are sampled at the falling edge, where both sides are
  // settled, and the model is advanced there.
  task automatic send_item(text_item_t it);
    bit taken;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_byte        <= it.b;
    in_first_byte  <= it.first;
    in_end_of_text <= it.eot;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      if (taken) decode_item(it);
      @(posedge clk);
    end
  endtask

  task automatic send_text();
    while (text_q.size() > 0) send_item(text_q.pop_front());
  endtask

  // Drops valid and waits until every owed result is back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (decoded_q.size() > 0) @(posedge clk);
  endtask

  // Receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // A result shown at the falling edge with no stall is taken at the next edge
  always @(negedge clk) begin
    decoded_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: out_byte=%h out_kind=%0d out_last_of_run=%0b",
               out_byte, out_kind, out_last_of_run);
        n_fail++;
      end else begin
        e = decoded_q.pop_front();
        if (out_byte !== e.data) begin
          $error("out_byte: expected %h, got %h", e.data, out_byte);
          n_fail++;
        end
        if (out_kind !== e.kind) begin
          $error("out_kind: expected %0d, got %0d", e.kind, out_kind);
          n_fail++;
        end
        if (out_last_of_run !== e.last) begin
          $error("out_last_of_run: expected %0b, got %0b", e.last, out_last_of_run);
          n_fail++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Opening byte that is not a quote, then an idle byte with end of text
  task automatic test_bad_opening();
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);
    send_text();
  endtask

  // Highest pair, U+10FFFF, gives the four-byte form
  task automatic test_top_surrogate_pair();
    push_byte(CH_QUOTE, 1'b1);
    push_uesc(16'hDBFF);
    push_uesc(16'hDFFF);
    push_byte(CH_QUOTE, 1'b0, 1'b1);
    send_text();
  endtask

  // Held high, a three-byte second escape and end of text on its last digit:
  // the largest burst one byte can cause
  task automatic test_largest_burst();
    push_byte(CH_QUOTE, 1'b1);
    push_uesc(16'hD800);
    push_uesc(16'hFFFF);
    text_q[text_q.size()-1].eot = 1'b1;
    send_text();
  endtask

  task automatic test_random(int idle_pct, int stall, int count);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    n_items = 0;
    while (n_items < count) begin
      push_string();
      send_text();
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the result queue
  // fills and the input stalls; then the sender waits for a full drain.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    in_valid <= 1'b0;
    @(negedge clk);
    hold_req = 80;
    @(posedge clk);
    n_items = 0;
    while (n_items < 30) begin
      push_string();
      send_text();
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    clear_decoder();

    test_bad_opening();
    test_top_surrogate_pair();
    test_largest_burst();
    test_random(0, 0, 80);
    test_random(74, 0, 80);
    test_random(0, 74, 80);
    test_random(31, 31, 80);
    test_backpressure();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("json_string_unescape_utf8_unit verification clean");
    end else begin
      $display("json_string_unescape_utf8_unit verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8_unit.sv
tb/json_string_unescape_utf8_unit_tb.sv
